// File: rtl/epss_pkg.sv
// ----------------------------------------------------------------------------
// epss_pkg
// Shared types, register codes and arithmetic helpers for the elastic/plastic
// strain split datapath.
// ----------------------------------------------------------------------------
package epss_pkg;

  // register map, word index taken from paddr[3:2]
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_YIELD = 2'd2;
  localparam logic [1:0] REG_SCALE = 2'd3;

  // split modes; the unused code behaves as the plain threshold split
  localparam logic [1:0] MODE_THRESH  = 2'd0;
  localparam logic [1:0] MODE_RO      = 2'd1;
  localparam logic [1:0] MODE_RESCALE = 2'd2;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [30:0] RO_MIN_RATIO = 31'd10737418;
  localparam logic [30:0] MAX31        = 31'h7fff_ffff;

  localparam logic [1:0]  RST_MODE  = MODE_RESCALE;
  localparam logic [30:0] RST_LIMIT = 31'd2147484;
  localparam logic [30:0] RST_YIELD = 31'd2147484;
  localparam logic [30:0] RST_SCALE = Q30_ONE;

  typedef struct packed {
    logic signed [31:0] strain_xx;
    logic signed [31:0] strain_yy;
    logic signed [31:0] strain_xy;
    logic        [30:0] total_von_mises;
  } epss_in_t;

  typedef struct packed {
    logic               part;
    logic signed [31:0] part_xx;
    logic signed [31:0] part_yy;
    logic signed [31:0] part_xy;
    logic signed [31:0] major_principal;
    logic signed [31:0] minor_principal;
    logic        [30:0] max_shear;
    logic        [30:0] part_von_mises;
    logic               plastic_zone;
    logic               last;
  } epss_out_t;

  // strain components of one part
  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] xy;
  } epss_comp_t;

  // derived values of one part
  typedef struct packed {
    logic signed [31:0] major;
    logic signed [31:0] minor;
    logic        [30:0] max_shear;
    logic        [30:0] von_mises;
  } epss_metrics_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [32:0] root;
  } epss_sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] quo;
  } epss_div_t;

  // one digit of a restoring square root, two radicand bits per step
  function automatic epss_sqrt_t sqrt_step(input logic [35:0] rem, input logic [32:0] root,
                                           input logic [1:0] pair);
    logic [35:0] r;
    logic [35:0] trial;
    epss_sqrt_t  o;
    r     = {rem[33:0], pair};
    trial = {1'b0, root, 2'b01};
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {root[31:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {root[31:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of a restoring divide; the first step compares without shifting
  function automatic epss_div_t div_step(input logic [31:0] rem, input logic [30:0] quo,
                                         input logic [30:0] den, input logic first);
    logic [31:0] r;
    epss_div_t   o;
    r = first ? rem : {rem[30:0], 1'b0};
    if (r >= {1'b0, den}) begin
      o.rem = r - {1'b0, den};
      o.quo = {quo[29:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {quo[29:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] o;
    if (v > 35'sd2147483647) begin
      o = 32'h7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      o = 32'h8000_0000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

endpackage

// File: rtl/elastic_plastic_strain_split.sv
// ----------------------------------------------------------------------------
// elastic_plastic_strain_split
// Splits each strain pixel into an elastic and a plastic part and reports
// principal strains, maximum shear and von Mises strain of both parts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one pixel request:
//   strain_xx, strain_yy, strain_xy and total_von_mises, all Q2.30.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns two requests
//   per pixel, the elastic part first (part=0), then the plastic part
//   (part=1, last=1).
//   The APB port sets mode, elastic_limit, yield_strain and plastic_scale at
//   byte addresses 0, 4, 8, 12; write it only while no pixel is in flight.
//   The elastic result reaches the output register through the stages below;
//   the plastic one follows the cycle after the elastic one is taken.
//   Throughput: a pixel may enter every cycle while the pipe is not held, but
//   the output port carries two results per pixel, which limits the sustained rate.
//   The 27 stages are an 8-stage ratio divider (4 quotient bits a stage),
//   7 split stages (squares, ratio, scaling multiplies), and per part a
//   12-stage metrics pipe with two square roots taking 4 digits a stage.
//   When the receiver stalls with both results still held, the whole pipe
//   holds; bubbles keep moving forward. Reset empties the pipe and output
//   register and loads the register defaults.
// ----------------------------------------------------------------------------
module elastic_plastic_strain_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  epss_pkg::epss_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output epss_pkg::epss_out_t out_data_o
);

  localparam int unsigned DivIter = 31;
  localparam int unsigned DivPer  = 4;
  localparam int unsigned DivStg  = (DivIter + DivPer - 1) / DivPer;
  localparam int unsigned SplStg  = 7;

  // divider stage: quotient of num * 2^30 / den, plus the pixel riding along
  typedef struct packed {
    logic [31:0]       rem;
    logic [30:0]       quo;
    logic [30:0]       den;
    logic [2:0][31:0]  tot;
    logic              ro;
    logic              resc;
    logic              over;
    logic              ro_zero;
    logic              ro_full;
  } div_st_t;

  // split stages share one layout; each stage fills what it needs
  typedef struct packed {
    logic [2:0][31:0]  tot;
    logic              ro;
    logic              resc;
    logic              over;
    logic              ro_zero;
    logic              ro_full;
    logic              zone;
    logic [63:0]       wide;
    logic [30:0]       ratio;
    logic [2:0][62:0]  prod;
    logic [2:0]        neg;
    logic [2:0][31:0]  el;
    logic [2:0][31:0]  pl;
  } spl_st_t;

  // ---------------------------------------------------------------- registers
  logic [1:0]  mode_q;
  logic [30:0] limit_q, yield_q, scale_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= epss_pkg::RST_MODE;
      limit_q <= epss_pkg::RST_LIMIT;
      yield_q <= epss_pkg::RST_YIELD;
      scale_q <= epss_pkg::RST_SCALE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        epss_pkg::REG_MODE:  mode_q  <= pwdata[1:0];
        epss_pkg::REG_LIMIT: limit_q <= pwdata[30:0];
        epss_pkg::REG_YIELD: yield_q <= pwdata[30:0];
        epss_pkg::REG_SCALE: scale_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      epss_pkg::REG_MODE:  prdata = {30'b0, mode_q};
      epss_pkg::REG_LIMIT: prdata = {1'b0, limit_q};
      epss_pkg::REG_YIELD: prdata = {1'b0, yield_q};
      epss_pkg::REG_SCALE: prdata = {1'b0, scale_q};
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  // The whole pipe moves together; it only holds when a finished pixel sits
  // in the last metrics stage and the output register cannot take it.
  logic en;
  logic ofree;
  logic el_v, pl_v;
  logic out_valid_q, out_sel_q;

  assign ofree      = !out_valid_q || (out_ready_i && out_sel_q);
  assign en         = !el_v || ofree;
  assign in_ready_o = en;

  // ---------------------------------------------------------------- divider
  // Threshold modes divide limit by vm (ratio below one when vm > limit).
  // Ramberg-Osgood divides vm by yield to get the normalized strain q.
  div_st_t div_init;
  div_st_t div_d [DivStg];
  div_st_t div_q [DivStg];
  logic [DivStg-1:0] div_v_q;

  always_comb begin
    div_init         = '0;
    div_init.ro      = (mode_q == epss_pkg::MODE_RO);
    div_init.resc    = (mode_q == epss_pkg::MODE_RESCALE);
    div_init.over    = in_data_i.total_von_mises > limit_q;
    div_init.ro_zero = in_data_i.total_von_mises == 31'd0;
    div_init.ro_full = {1'b0, in_data_i.total_von_mises} >= {yield_q, 1'b0};
    div_init.den     = div_init.ro ? yield_q : in_data_i.total_von_mises;
    div_init.rem     = {1'b0, div_init.ro ? in_data_i.total_von_mises : limit_q};
    div_init.tot[0]  = in_data_i.strain_xx;
    div_init.tot[1]  = in_data_i.strain_yy;
    div_init.tot[2]  = in_data_i.strain_xy;
  end

  for (genvar j = 0; j < DivStg; j++) begin : g_div
    always_comb begin
      div_st_t             st;
      epss_pkg::epss_div_t r;
      st = (j == 0) ? div_init : div_q[(j == 0) ? 0 : j-1];
      for (int t = 0; t < DivPer; t++) begin
        if (j * DivPer + t < DivIter) begin
          r      = epss_pkg::div_step(st.rem, st.quo, st.den, (j * DivPer + t) == 0);
          st.rem = r.rem;
          st.quo = r.quo;
        end
      end
      div_d[j] = st;
    end
  end

  // ---------------------------------------------------------------- split
  spl_st_t spl_d [SplStg];
  spl_st_t spl_q [SplStg];
  logic [SplStg-1:0] spl_v_q;

  always_comb begin
    logic [61:0]        qq;
    logic [30:0]        r_ro;
    logic [31:0]        mag;
    logic [63:0]        rsum;
    logic signed [34:0] pv;
    logic [31:0]        pp;
    logic [31:0]        pl2;

    for (int k = 1; k < SplStg; k++) begin
      spl_d[k] = spl_q[k-1];
    end

    // stage 0: q^2 for Ramberg-Osgood, ratio for the threshold law
    qq               = div_q[DivStg-1].quo * div_q[DivStg-1].quo;
    spl_d[0]         = '0;
    spl_d[0].tot     = div_q[DivStg-1].tot;
    spl_d[0].ro      = div_q[DivStg-1].ro;
    spl_d[0].resc    = div_q[DivStg-1].resc;
    spl_d[0].over    = div_q[DivStg-1].over;
    spl_d[0].ro_zero = div_q[DivStg-1].ro_zero;
    spl_d[0].ro_full = div_q[DivStg-1].ro_full;
    spl_d[0].wide    = {32'b0, qq[61:30]};
    spl_d[0].ratio   = div_q[DivStg-1].over ? div_q[DivStg-1].quo : epss_pkg::Q30_ONE;

    // stage 1: q^4
    spl_d[1].wide = spl_q[0].wide[31:0] * spl_q[0].wide[31:0];

    // stage 2: final ratio and plastic zone
    if (spl_q[1].ro_zero) begin
      r_ro = '0;
    end else if (spl_q[1].ro_full) begin
      r_ro = epss_pkg::Q30_ONE;
    end else if (spl_q[1].wide[63:31] > {2'b0, epss_pkg::Q30_ONE}) begin
      r_ro = epss_pkg::Q30_ONE;
    end else begin
      r_ro = spl_q[1].wide[61:31];
    end
    if (spl_q[1].ro) begin
      spl_d[2].zone  = r_ro > epss_pkg::RO_MIN_RATIO;
      spl_d[2].ratio = (r_ro > epss_pkg::RO_MIN_RATIO) ? r_ro : 31'd0;
    end else begin
      spl_d[2].zone  = spl_q[1].over;
      spl_d[2].ratio = spl_q[1].ratio;
    end

    // stage 3: |c| * ratio
    for (int k = 0; k < 3; k++) begin
      mag                 = spl_q[2].tot[k][31] ? (~spl_q[2].tot[k] + 32'd1) : spl_q[2].tot[k];
      spl_d[3].prod[k]    = mag * spl_q[2].ratio;
      spl_d[3].neg[k]     = spl_q[2].tot[k][31];
    end

    // stage 4: round half away from zero, assign scaled share to its part
    for (int k = 0; k < 3; k++) begin
      rsum = {1'b0, spl_q[3].prod[k]} + 64'd536870912;
      pv   = spl_q[3].neg[k] ? -$signed({1'b0, rsum[63:30]}) : $signed({1'b0, rsum[63:30]});
      pp   = pv[31:0];
      if (spl_q[3].ro) begin
        spl_d[4].pl[k] = pp;
        spl_d[4].el[k] = spl_q[3].tot[k] - pp;
      end else begin
        spl_d[4].el[k] = pp;
        spl_d[4].pl[k] = spl_q[3].tot[k] - pp;
      end
    end

    // stage 5: |plastic| * scale
    for (int k = 0; k < 3; k++) begin
      mag              = spl_q[4].pl[k][31] ? (~spl_q[4].pl[k] + 32'd1) : spl_q[4].pl[k];
      spl_d[5].prod[k] = mag * scale_q;
      spl_d[5].neg[k]  = spl_q[4].pl[k][31];
    end

    // stage 6: in rescale mode, rescaled plastic part, elastic as the remainder, saturated
    for (int k = 0; k < 3; k++) begin
      rsum = {1'b0, spl_q[5].prod[k]} + 64'd536870912;
      pv   = spl_q[5].neg[k] ? -$signed({1'b0, rsum[63:30]}) : $signed({1'b0, rsum[63:30]});
      pl2  = epss_pkg::sat32(pv);
      if (spl_q[5].resc) begin
        spl_d[6].pl[k] = pl2;
        spl_d[6].el[k] = epss_pkg::sat32($signed({{3{spl_q[5].tot[k][31]}}, spl_q[5].tot[k]})
                                         - $signed({{3{pl2[31]}}, pl2}));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q <= '0;
      spl_v_q <= '0;
    end else if (en) begin
      div_v_q <= {div_v_q[DivStg-2:0], in_valid_i};
      spl_v_q <= {spl_v_q[SplStg-2:0], div_v_q[DivStg-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q <= div_d;
      spl_q <= spl_d;
    end
  end

  // ---------------------------------------------------------------- metrics
  epss_pkg::epss_comp_t    el_in, pl_in, el_comp, pl_comp;
  epss_pkg::epss_metrics_t el_met, pl_met;
  logic                    el_zone, pl_zone;

  assign el_in = '{xx: spl_q[SplStg-1].el[0], yy: spl_q[SplStg-1].el[1],
                   xy: spl_q[SplStg-1].el[2]};
  assign pl_in = '{xx: spl_q[SplStg-1].pl[0], yy: spl_q[SplStg-1].pl[1],
                   xy: spl_q[SplStg-1].pl[2]};

  epss_metrics u_el_metrics (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (spl_v_q[SplStg-1]),
    .comp_i    (el_in),
    .zone_i    (spl_q[SplStg-1].zone),
    .valid_o   (el_v),
    .comp_o    (el_comp),
    .zone_o    (el_zone),
    .metrics_o (el_met)
  );

  epss_metrics u_pl_metrics (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (spl_v_q[SplStg-1]),
    .comp_i    (pl_in),
    .zone_i    (spl_q[SplStg-1].zone),
    .valid_o   (pl_v),
    .comp_o    (pl_comp),
    .zone_o    (pl_zone),
    .metrics_o (pl_met)
  );

  // ---------------------------------------------------------------- output
  // Hold both results of one pixel; send elastic, then plastic, then load
  // the next pixel in the cycle the plastic request is taken.
  epss_pkg::epss_out_t el_res_q, pl_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_sel_q   <= 1'b0;
    end else if (ofree) begin
      out_valid_q <= el_v;
      out_sel_q   <= 1'b0;
    end else if (out_ready_i) begin
      out_sel_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ofree && el_v) begin
      el_res_q <= '{part: 1'b0, part_xx: el_comp.xx, part_yy: el_comp.yy,
                    part_xy: el_comp.xy, major_principal: el_met.major,
                    minor_principal: el_met.minor, max_shear: el_met.max_shear,
                    part_von_mises: el_met.von_mises, plastic_zone: el_zone,
                    last: 1'b0};
      pl_res_q <= '{part: 1'b1, part_xx: pl_comp.xx, part_yy: pl_comp.yy,
                    part_xy: pl_comp.xy, major_principal: pl_met.major,
                    minor_principal: pl_met.minor, max_shear: pl_met.max_shear,
                    part_von_mises: pl_met.von_mises, plastic_zone: pl_zone,
                    last: 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_sel_q ? pl_res_q : el_res_q;

  // ---------------------------------------------------------------- checks
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    el_v == pl_v)
    else $error("elastic and plastic metric lanes out of step");

  a_plastic_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_sel_q |=> out_valid_o && out_sel_q)
    else $error("plastic request did not follow elastic request");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && el_v)
    else $error("input held without a full output");

  a_no_zone_no_plastic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_sel_q && !out_data_o.plastic_zone |->
      out_data_o.part_xx == 32'sd0 && out_data_o.part_yy == 32'sd0 &&
      out_data_o.part_xy == 32'sd0)
    else $error("plastic strain outside plastic zone");

endmodule

// File: rtl/epss_metrics.sv
// ----------------------------------------------------------------------------
// epss_metrics
// Principal strains, maximum shear and von Mises strain of one strain part,
// pipelined: squares, sums, two square roots four digits a stage, limits.
// ----------------------------------------------------------------------------
module epss_metrics (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  epss_pkg::epss_comp_t   comp_i,
  input  logic                   zone_i,
  output logic                   valid_o,
  output epss_pkg::epss_comp_t   comp_o,
  output logic                   zone_o,
  output epss_pkg::epss_metrics_t metrics_o
);

  localparam int unsigned SqIter = 33;
  localparam int unsigned SqPer  = 4;
  localparam int unsigned SqStg  = (SqIter + SqPer - 1) / SqPer;

  typedef struct packed {
    logic        [63:0] dsq;
    logic        [62:0] g2;
    logic signed [63:0] ab;
    logic signed [32:0] sum;
    epss_pkg::epss_comp_t comp;
    logic               zone;
  } sq_in_t;

  typedef struct packed {
    logic        [35:0] rem_m;
    logic        [35:0] rem_v;
    logic        [32:0] root_m;
    logic        [32:0] root_v;
    logic        [65:0] x_m;
    logic        [65:0] x_v;
    logic signed [32:0] sum;
    epss_pkg::epss_comp_t comp;
    logic               zone;
  } sq_st_t;

  sq_in_t  m0_d, m0_q;
  sq_st_t  m1_d, m1_q;
  sq_st_t  sq_d [SqStg];
  sq_st_t  sq_q [SqStg];
  logic    m0_v_q, m1_v_q, fin_v_q;
  logic    [SqStg-1:0] sq_v_q;
  epss_pkg::epss_metrics_t fin_d, fin_q;
  epss_pkg::epss_comp_t    fin_comp_q;
  logic                    fin_zone_q;

  // squares and cross product
  always_comb begin
    logic signed [32:0] d;
    logic        [32:0] dmag;
    logic        [31:0] gmag;
    d    = {comp_i.xx[31], comp_i.xx} - {comp_i.yy[31], comp_i.yy};
    dmag = d[32] ? 33'(-d) : d;
    gmag = comp_i.xy[31] ? (~comp_i.xy + 32'd1) : comp_i.xy;
    m0_d.dsq  = dmag[31:0] * dmag[31:0];
    m0_d.g2   = gmag * gmag;
    m0_d.ab   = comp_i.xx * comp_i.yy;
    m0_d.sum  = {comp_i.xx[31], comp_i.xx} + {comp_i.yy[31], comp_i.yy};
    m0_d.comp = comp_i;
    m0_d.zone = zone_i;
  end

  // radicands: (a-b)^2 + 4g^2 and a^2 - ab + b^2 + 3g^2
  always_comb begin
    logic signed [66:0] v;
    v = $signed({3'b0, m0_q.dsq}) + 67'(m0_q.ab) + $signed({4'b0, m0_q.g2})
        + $signed({3'b0, m0_q.g2, 1'b0});
    m1_d        = '0;
    m1_d.x_m    = {2'b0, m0_q.dsq} + {1'b0, m0_q.g2, 2'b00};
    m1_d.x_v    = v[65:0];
    m1_d.sum    = m0_q.sum;
    m1_d.comp   = m0_q.comp;
    m1_d.zone   = m0_q.zone;
  end

  for (genvar j = 0; j < SqStg; j++) begin : g_sq
    always_comb begin
      sq_st_t              st;
      epss_pkg::epss_sqrt_t r;
      st = (j == 0) ? m1_q : sq_q[(j == 0) ? 0 : j-1];
      for (int t = 0; t < SqPer; t++) begin
        if (j * SqPer + t < SqIter) begin
          r         = epss_pkg::sqrt_step(st.rem_m, st.root_m, st.x_m[65:64]);
          st.rem_m  = r.rem;
          st.root_m = r.root;
          st.x_m    = {st.x_m[63:0], 2'b00};
          r         = epss_pkg::sqrt_step(st.rem_v, st.root_v, st.x_v[65:64]);
          st.rem_v  = r.rem;
          st.root_v = r.root;
          st.x_v    = {st.x_v[63:0], 2'b00};
        end
      end
      sq_d[j] = st;
    end
  end

  // limits and half sums
  always_comb begin
    logic        [32:0] m;
    logic        [32:0] v;
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    m  = sq_q[SqStg-1].root_m;
    v  = sq_q[SqStg-1].root_v;
    hi = $signed({{2{sq_q[SqStg-1].sum[32]}}, sq_q[SqStg-1].sum}) + $signed({2'b0, m});
    lo = $signed({{2{sq_q[SqStg-1].sum[32]}}, sq_q[SqStg-1].sum}) - $signed({2'b0, m});
    fin_d.major     = epss_pkg::sat32({hi[34], hi[34:1]});
    fin_d.minor     = epss_pkg::sat32({lo[34], lo[34:1]});
    fin_d.max_shear = (m > {2'b0, epss_pkg::MAX31}) ? epss_pkg::MAX31 : m[30:0];
    fin_d.von_mises = (v > {2'b0, epss_pkg::MAX31}) ? epss_pkg::MAX31 : v[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m0_v_q  <= 1'b0;
      m1_v_q  <= 1'b0;
      sq_v_q  <= '0;
      fin_v_q <= 1'b0;
    end else if (en_i) begin
      m0_v_q  <= valid_i;
      m1_v_q  <= m0_v_q;
      sq_v_q  <= {sq_v_q[SqStg-2:0], m1_v_q};
      fin_v_q <= sq_v_q[SqStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q       <= m0_d;
      m1_q       <= m1_d;
      sq_q       <= sq_d;
      fin_q      <= fin_d;
      fin_comp_q <= sq_q[SqStg-1].comp;
      fin_zone_q <= sq_q[SqStg-1].zone;
    end
  end

  assign valid_o   = fin_v_q;
  assign comp_o    = fin_comp_q;
  assign zone_o    = fin_zone_q;
  assign metrics_o = fin_q;

endmodule
